/* design/v2alu_pkg.sv */
// shared constants for the 2d vector alu: opcodes, angle and cordic constants
package v2alu_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_COUNT       = 24;

   localparam logic [3:0] OP_ADDV = 4'd0;
   localparam logic [3:0] OP_ADDS = 4'd1;
   localparam logic [3:0] OP_SUBV = 4'd2;
   localparam logic [3:0] OP_SUBS = 4'd3;
   localparam logic [3:0] OP_MULV = 4'd4;
   localparam logic [3:0] OP_MULS = 4'd5;
   localparam logic [3:0] OP_DIVV = 4'd6;
   localparam logic [3:0] OP_DIVS = 4'd7;
   localparam logic [3:0] OP_NORM = 4'd8;
   localparam logic [3:0] OP_ROT  = 4'd9;

   // degrees in q16.16
   localparam logic signed [26:0] ANG_FULL    = 27'sd23592960;
   localparam logic signed [26:0] ANG_HALF    = 27'sd11796480;
   localparam logic signed [26:0] ANG_QUARTER = 27'sd5898240;

   localparam logic [31:0]        PI_Q30   = 32'd3373259426;
   localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
   localparam logic [7:0]         DEG_HALF = 8'd180;

   localparam logic [30:0] ATAN_Q30 [ATAN_COUNT] = '{
      31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
      31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
      31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
      31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256, 31'd128
   };

endpackage

/* design/vector2d_alu_top.sv */
// 2d vector alu in signed fixed point: add, sub, mul, div, normalize, cordic rotate
// One word is taken every clock cycle unless the result side stalls. Each word passes in
// turn through the input register and two setup stages, the 32-stage square root (for
// normalize), which also hosts the angle scaling and the cordic steps,
// one gain stage, the 33-stage divider with one lane per component and the output
// stage. When the result side stalls the whole pipe holds, and the input is ready again
// as soon as the last stage is taken. Divide by zero gives a zero component and
// div_zero; every component is clamped to 32 bits and flagged.
module vector2d_alu_top
   import v2alu_pkg::*;
#(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_ax,
   input  logic signed [31:0] req_ay,
   input  logic signed [31:0] req_bx,
   input  logic signed [31:0] req_by,
   input  logic signed [31:0] req_scalar,
   input  logic signed [25:0] req_angle_deg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_rx,
   output logic signed [31:0] rsp_ry,
   output logic               rsp_div_zero,
   output logic               rsp_saturated
);

   localparam int SQ_STAGES  = 32;
   localparam int DIV180_STG = 8;
   localparam int DIV_BITS   = 33;
   localparam int B0         = 3;
   localparam int P3         = B0 + SQ_STAGES;
   localparam int D0         = P3 + 1;
   localparam int PF         = D0 + DIV_BITS;
   localparam int NST        = PF + 1;
   localparam logic signed [63:0] MUL_RND = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [65:0] ROT_RND = 66'sd1 <<< 29;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] sc;
      logic signed [25:0] deg;
      logic [31:0]        amx;
      logic [31:0]        amy;
      logic               axneg;
      logic               ayneg;
      logic [31:0]        dvx;
      logic [31:0]        dvy;
      logic               dxneg;
      logic               dyneg;
      logic               dzx;
      logic               dzy;
      logic signed [63:0] prx;
      logic signed [63:0] pry;
      logic [63:0]        sqx;
      logic [63:0]        sqy;
      logic [63:0]        n;
      logic [55:0]        angm;
      logic [38:0]        v;
      logic               zneg;
      logic [7:0]         ra;
      logic [31:0]        qa;
      logic signed [35:0] cx;
      logic signed [35:0] cy;
      logic signed [32:0] cz;
      logic [34:0]        srem;
      logic [31:0]        sroot;
      logic signed [65:0] gx;
      logic signed [65:0] gy;
      logic [31:0]        drx;
      logic [31:0]        dry;
      logic [32:0]        qx;
      logic [32:0]        qy;
      logic               ovx;
      logic               ovy;
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic               sat;
      logic               dz;
   } stage_type;

   stage_type st_ff [NST];
   stage_type st_in [NST];
   logic [NST-1:0] valid_ff;
   logic           adv;

   function automatic logic [32:0] clamp32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) begin
         r = {1'b1, 32'h7fffffff};
      end else if (v < -66'sd2147483648) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   function automatic logic [32:0] div_step(input logic [31:0] r, input logic b,
                                            input logic [31:0] d);
      logic [32:0] t;
      logic [32:0] r_out;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         r_out = {1'b1, 32'(t - {1'b0, d})};
      end else begin
         r_out = {1'b0, t[31:0]};
      end
      return r_out;
   endfunction

   function automatic logic [32:0] div_result(input logic [32:0] q, input logic ov,
                                              input logic neg);
      logic [32:0]        m;
      logic signed [33:0] sv;
      m = ov ? '1 : q;
      sv = $signed({1'b0, m});
      if (neg) begin
         sv = -sv;
      end
      return clamp32(66'(sv));
   endfunction

   assign adv       = !valid_ff[NST-1] || rsp_ready;
   assign req_ready = adv;

   // input capture
   always_comb begin
      st_in[0]     = '0;
      st_in[0].op  = req_opcode;
      st_in[0].ax  = req_ax;
      st_in[0].ay  = req_ay;
      st_in[0].bx  = req_bx;
      st_in[0].by  = req_by;
      st_in[0].sc  = req_scalar;
      st_in[0].deg = req_angle_deg;
   end

   // products, add/sub, angle fold, divisor setup
   always_comb begin : s1
      stage_type          s;
      logic signed [31:0] mbx;
      logic signed [31:0] mby;
      logic signed [26:0] dw;
      logic signed [26:0] df;
      logic [22:0]        dm;
      logic               flip;
      logic [32:0]        tx;
      logic [32:0]        ty;
      s = st_ff[0];
      s.amx = s.ax[31] ? 32'(-s.ax) : 32'(s.ax);
      s.amy = s.ay[31] ? 32'(-s.ay) : 32'(s.ay);
      s.axneg = s.ax[31];
      s.ayneg = s.ay[31];
      mbx = (s.op == OP_MULS) ? s.sc : s.bx;
      mby = (s.op == OP_MULS) ? s.sc : s.by;
      s.prx = 64'(s.ax) * 64'(mbx);
      s.pry = 64'(s.ay) * 64'(mby);
      s.sqx = 64'(s.amx) * 64'(s.amx);
      s.sqy = 64'(s.amy) * 64'(s.amy);
      dw = 27'(s.deg);
      if (dw >= ANG_HALF) begin
         dw = dw - ANG_FULL;
      end else if (dw < -ANG_HALF) begin
         dw = dw + ANG_FULL;
      end
      flip = 1'b0;
      df = dw;
      if (dw > ANG_QUARTER) begin
         df = dw - ANG_HALF;
         flip = 1'b1;
      end else if (dw < -ANG_QUARTER) begin
         df = dw + ANG_HALF;
         flip = 1'b1;
      end
      dm = df[26] ? 23'(-df) : 23'(df);
      s.zneg = df[26];
      s.angm = 56'(dm) * 56'(PI_Q30);
      s.cx = flip ? -36'(s.ax) : 36'(s.ax);
      s.cy = flip ? -36'(s.ay) : 36'(s.ay);
      if (s.op == OP_DIVS) begin
         s.dvx = s.sc[31] ? 32'(-s.sc) : 32'(s.sc);
         s.dvy = s.dvx;
         s.dxneg = s.sc[31];
         s.dyneg = s.sc[31];
         s.dzx = (s.sc == 32'sd0);
         s.dzy = s.dzx;
      end else begin
         s.dvx = s.bx[31] ? 32'(-s.bx) : 32'(s.bx);
         s.dvy = s.by[31] ? 32'(-s.by) : 32'(s.by);
         s.dxneg = s.bx[31];
         s.dyneg = s.by[31];
         s.dzx = (s.bx == 32'sd0);
         s.dzy = (s.by == 32'sd0);
      end
      s.rx = '0;
      s.ry = '0;
      s.sat = 1'b0;
      s.dz = 1'b0;
      tx = '0;
      ty = '0;
      case (s.op)
         OP_ADDV: begin
            tx = clamp32(66'(s.ax) + 66'(s.bx));
            ty = clamp32(66'(s.ay) + 66'(s.by));
         end
         OP_ADDS: begin
            tx = clamp32(66'(s.ax) + 66'(s.sc));
            ty = clamp32(66'(s.ay) + 66'(s.sc));
         end
         OP_SUBV: begin
            tx = clamp32(66'(s.ax) - 66'(s.bx));
            ty = clamp32(66'(s.ay) - 66'(s.by));
         end
         OP_SUBS: begin
            tx = clamp32(66'(s.ax) - 66'(s.sc));
            ty = clamp32(66'(s.ay) - 66'(s.sc));
         end
         default: begin
            tx = '0;
            ty = '0;
         end
      endcase
      s.rx = $signed(tx[31:0]);
      s.ry = $signed(ty[31:0]);
      s.sat = tx[32] | ty[32];
      st_in[1] = s;
   end

   // multiply rounding, sum of squares, angle scaling setup
   always_comb begin : s2
      stage_type   s;
      logic [32:0] tx;
      logic [32:0] ty;
      s = st_ff[1];
      tx = '0;
      ty = '0;
      if (s.op == OP_MULV || s.op == OP_MULS) begin
         tx = clamp32(66'((s.prx + MUL_RND) >>> FRAC_BITS));
         ty = clamp32(66'((s.pry + MUL_RND) >>> FRAC_BITS));
         s.rx = $signed(tx[31:0]);
         s.ry = $signed(ty[31:0]);
         s.sat = tx[32] | ty[32];
      end
      s.n = s.sqx + s.sqy;
      s.v = s.angm[54:16];
      s.ra = {1'b0, s.angm[54:48]};
      s.qa = '0;
      s.srem = '0;
      s.sroot = '0;
      st_in[2] = s;
   end

   // square root one bit per stage; angle divide by 180 then cordic steps alongside
   for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
      localparam int AI = (j >= DIV180_STG && j - DIV180_STG < ATAN_COUNT) ?
                          j - DIV180_STG : 0;
      always_comb begin
         stage_type          s;
         logic [34:0]        t;
         logic [34:0]        trial;
         logic [8:0]         t9;
         logic signed [35:0] dx;
         logic signed [35:0] dy;
         s = st_ff[B0+j-1];
         t9 = '0;
         dx = '0;
         dy = '0;
         t = {s.srem[32:0], s.n[63-2*j -: 2]};
         trial = {1'b0, s.sroot, 2'b01};
         if (t >= trial) begin
            s.srem = t - trial;
            s.sroot = {s.sroot[30:0], 1'b1};
         end else begin
            s.srem = t;
            s.sroot = {s.sroot[30:0], 1'b0};
         end
         if (j < DIV180_STG) begin
            for (int b = 0; b < 4; b++) begin
               t9 = {s.ra, s.v[31-4*j-b]};
               if (t9 >= {1'b0, DEG_HALF}) begin
                  s.ra = 8'(t9 - {1'b0, DEG_HALF});
                  s.qa[31-4*j-b] = 1'b1;
               end else begin
                  s.ra = t9[7:0];
               end
            end
            if (j == DIV180_STG - 1) begin
               s.cz = s.zneg ? -33'(s.qa) : 33'(s.qa);
            end
         end else if (j < DIV180_STG + CORDIC_STEPS) begin
            dx = s.cy >>> AI;
            dy = s.cx >>> AI;
            if (!s.cz[32]) begin
               s.cx = s.cx - dx;
               s.cy = s.cy + dy;
               s.cz = s.cz - 33'(ATAN_Q30[AI]);
            end else begin
               s.cx = s.cx + dx;
               s.cy = s.cy - dy;
               s.cz = s.cz + 33'(ATAN_Q30[AI]);
            end
         end
         st_in[B0+j] = s;
      end
   end

   // cordic gain products, norm divisor, divider start
   always_comb begin : s3
      stage_type s;
      s = st_ff[P3-1];
      s.gx = 66'(s.cx) * 66'(GAIN_Q30);
      s.gy = 66'(s.cy) * 66'(GAIN_Q30);
      if (s.op == OP_NORM) begin
         s.dvx = s.sroot;
         s.dvy = s.sroot;
         s.dxneg = 1'b0;
         s.dyneg = 1'b0;
         s.dzx = (s.sroot == 32'd0);
         s.dzy = s.dzx;
      end
      s.drx = s.amx >> (DIV_BITS - FRAC_BITS);
      s.dry = s.amy >> (DIV_BITS - FRAC_BITS);
      s.ovx = (s.drx >= s.dvx);
      s.ovy = (s.dry >= s.dvy);
      s.qx = '0;
      s.qy = '0;
      st_in[P3] = s;
   end

   // restoring divide, one quotient bit per stage on each lane
   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      localparam int  QI  = DIV_BITS - 1 - k;
      localparam bit  HAS = (QI >= FRAC_BITS);
      localparam int  DI  = HAS ? QI - FRAC_BITS : 0;
      always_comb begin
         stage_type   s;
         logic [32:0] rsx;
         logic [32:0] rsy;
         logic [32:0] tx;
         logic [32:0] ty;
         s = st_ff[D0+k-1];
         tx = '0;
         ty = '0;
         rsx = div_step(s.drx, HAS ? s.amx[DI] : 1'b0, s.dvx);
         rsy = div_step(s.dry, HAS ? s.amy[DI] : 1'b0, s.dvy);
         s.drx = rsx[31:0];
         s.dry = rsy[31:0];
         s.qx[QI] = rsx[32];
         s.qy[QI] = rsy[32];
         if (k == 0 && s.op == OP_ROT) begin
            tx = clamp32((s.gx + ROT_RND) >>> 30);
            ty = clamp32((s.gy + ROT_RND) >>> 30);
            s.rx = $signed(tx[31:0]);
            s.ry = $signed(ty[31:0]);
            s.sat = tx[32] | ty[32];
         end
         st_in[D0+k] = s;
      end
   end

   // divide results: sign, zero divisor, clamp
   always_comb begin : sf
      stage_type   s;
      logic [32:0] tx;
      logic [32:0] ty;
      s = st_ff[PF-1];
      tx = div_result(s.qx, s.ovx, s.axneg ^ s.dxneg);
      ty = div_result(s.qy, s.ovy, s.ayneg ^ s.dyneg);
      if (s.dzx) begin
         tx = '0;
      end
      if (s.dzy) begin
         ty = '0;
      end
      case (s.op)
         OP_DIVV, OP_DIVS, OP_NORM: begin
            s.rx = $signed(tx[31:0]);
            s.ry = $signed(ty[31:0]);
            s.sat = tx[32] | ty[32];
            s.dz = s.dzx | s.dzy;
         end
         default: begin
            s.dz = 1'b0;
         end
      endcase
      st_in[PF] = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NST-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NST; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign rsp_valid     = valid_ff[NST-1];
   assign rsp_rx        = st_ff[NST-1].rx;
   assign rsp_ry        = st_ff[NST-1].ry;
   assign rsp_div_zero  = st_ff[NST-1].dz;
   assign rsp_saturated = st_ff[NST-1].sat;

endmodule

/* test/vector2d_alu_top_tb.sv */
// self-checking testbench for the 2d vector alu: directed and random words
`timescale 1ns / 100ps
module vector2d_alu_top_tb;
   import v2alu_pkg::*;

   localparam int FB = 16;
   localparam int STEPS = 16;
   localparam int LATENCY = 70;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic               div_zero;
      logic               saturated;
   } vec_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [3:0]         req_opcode;
   logic signed [31:0] req_ax, req_ay, req_bx, req_by, req_scalar;
   logic signed [25:0] req_angle_deg;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_rx, rsp_ry;
   logic               rsp_div_zero, rsp_saturated;

   vec_result_type expected_results[$];
   int          errors;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          idle_cycles;
   bit          done;

   vector2d_alu_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_ax(req_ax), .req_ay(req_ay), .req_bx(req_bx), .req_by(req_by),
      .req_scalar(req_scalar), .req_angle_deg(req_angle_deg),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_rx(rsp_rx), .rsp_ry(rsp_ry),
      .rsp_div_zero(rsp_div_zero), .rsp_saturated(rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
      return v >>> s;
   endfunction

   function automatic logic signed [63:0] clamp32(logic signed [63:0] v, inout logic flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
      return floor_shift(a * b + (64'sd1 <<< (FB - 1)), FB);
   endfunction

   function automatic logic signed [63:0] fx_div(logic signed [63:0] a, logic signed [63:0] b);
      return (a * (64'sd1 <<< FB)) / b;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic vec_result_type alu_predict(logic [3:0] op, logic signed [31:0] ax,
         logic signed [31:0] ay, logic signed [31:0] bx, logic signed [31:0] by,
         logic signed [31:0] sc, logic signed [25:0] ang);
      logic signed [63:0] x, y, z, dx, dy, deg, len, a_x, a_y;
      logic [63:0] mx, my;
      logic dz, sat;
      vec_result_type res;
      x = 0; y = 0; dz = 0; sat = 0;
      a_x = ax; a_y = ay;
      case (op)
         OP_ADDV: begin x = a_x + bx; y = a_y + by; end
         OP_ADDS: begin x = a_x + sc; y = a_y + sc; end
         OP_SUBV: begin x = a_x - bx; y = a_y - by; end
         OP_SUBS: begin x = a_x - sc; y = a_y - sc; end
         OP_MULV: begin x = fx_mul(a_x, bx); y = fx_mul(a_y, by); end
         OP_MULS: begin x = fx_mul(a_x, sc); y = fx_mul(a_y, sc); end
         OP_DIVV: begin
            if (bx == 0) dz = 1; else x = fx_div(a_x, bx);
            if (by == 0) dz = 1; else y = fx_div(a_y, by);
         end
         OP_DIVS: begin
            if (sc == 0) dz = 1;
            else begin x = fx_div(a_x, sc); y = fx_div(a_y, sc); end
         end
         OP_NORM: begin
            mx = a_x < 0 ? -a_x : a_x;
            my = a_y < 0 ? -a_y : a_y;
            len = int_sqrt(mx * mx + my * my);
            if (len == 0) dz = 1;
            else begin x = fx_div(a_x, len); y = fx_div(a_y, len); end
         end
         OP_ROT: begin
            deg = ang;
            x = a_x; y = a_y;
            while (deg >= ANG_HALF) deg = deg - ANG_FULL;
            while (deg < -ANG_HALF) deg = deg + ANG_FULL;
            if (deg > ANG_QUARTER) begin
               deg = deg - ANG_HALF; x = -x; y = -y;
            end else if (deg < -ANG_QUARTER) begin
               deg = deg + ANG_HALF; x = -x; y = -y;
            end
            z = (deg * $signed({32'd0, PI_Q30})) / ANG_HALF;
            for (int i = 0; i < STEPS && i < ATAN_COUNT; i++) begin
               dx = floor_shift(y, i);
               dy = floor_shift(x, i);
               if (z >= 0) begin
                  x = x - dx; y = y + dy; z = z - $signed({33'd0, ATAN_Q30[i]});
               end else begin
                  x = x + dx; y = y - dy; z = z + $signed({33'd0, ATAN_Q30[i]});
               end
            end
            x = floor_shift(x * GAIN_Q30 + (64'sd1 <<< 29), 30);
            y = floor_shift(y * GAIN_Q30 + (64'sd1 <<< 29), 30);
         end
         default: ;
      endcase
      x = clamp32(x, sat);
      y = clamp32(y, sat);
      res.rx = x[31:0];
      res.ry = y[31:0];
      res.div_zero = dz;
      res.saturated = sat;
      return res;
   endfunction

   task automatic send_word(logic [3:0] op, logic signed [31:0] ax, logic signed [31:0] ay,
         logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] sc,
         logic signed [25:0] ang);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_ax <= ax; req_ay <= ay; req_bx <= bx; req_by <= by;
      req_scalar <= sc; req_angle_deg <= ang;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(alu_predict(op, ax, ay, bx, by, sc, ang));
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_component();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(8) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
         2: return 0;
         3: return $signed($urandom_range(2000000)) - 1000000;
         4: return $signed($urandom_range(1 << 21)) - (1 << 20);
         default: return $signed($urandom_range(2 << 16)) - (1 << 16);
      endcase
   endfunction

   function automatic logic [25:0] rand_angle();
      case ($urandom_range(3))
         0: return 26'($urandom);
         1: return 26'($signed($urandom_range(2 * 23592960)) - 23592960);
         2: return 26'($signed($urandom_range(8)) * 45 - 180) << 16;
         default: return 26'($signed($urandom_range(2 * 5898240)) - 5898240);
      endcase
   endfunction

   task automatic test_directed();
      send_word(OP_ADDV, 32'h7fff_ffff, 32'h8000_0000, 1, -1, 0, 0);
      send_word(OP_ADDS, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000, 0);
      send_word(OP_SUBV, 32'h8000_0000, 32'h7fff_ffff, 1, -1, 0, 0);
      send_word(OP_SUBS, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 0);
      send_word(OP_MULV, 32'h0001_8000, -32'sh0000_8000, 32'h0002_0000, 32'h0000_0001, 0, 0);
      send_word(OP_MULV, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
      send_word(OP_MULS, 32'h0003_0000, -32'sh0003_0000, 0, 0, 32'h0000_8000, 0);
      send_word(OP_DIVV, 32'h0001_0000, 32'h0005_0000, 0, 32'h0002_0000, 0, 0);
      send_word(OP_DIVV, 32'h8000_0000, 32'h7fff_ffff, 1, -1, 0, 0);
      send_word(OP_DIVS, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0);
      send_word(OP_DIVS, -32'sh0007_0000, 32'h0002_0000, 0, 0, 32'h0003_0000, 0);
      send_word(OP_NORM, 0, 0, 0, 0, 0, 0);
      send_word(OP_NORM, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0);
      send_word(OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
      send_word(OP_NORM, 1, 0, 0, 0, 0, 0);
      send_word(OP_ROT, 32'h0001_0000, 0, 0, 0, 0, 26'sd5898240);
      send_word(OP_ROT, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, 26'sd11796480);
      send_word(OP_ROT, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, -26'sd11796480);
      send_word(OP_ROT, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 26'sd2949120);
      send_word(OP_ROT, 32'h0001_0000, 0, 0, 0, 0, 26'h1ff_ffff);
      send_word(OP_ROT, 32'h0001_0000, 0, 0, 0, 0, 26'h200_0000);
      send_word(4'd10, 5, 6, 7, 8, 9, 10);
      send_word(4'd15, -1, -1, -1, -1, -1, -1);
   endtask

   task automatic test_random(int count);
      logic [3:0] op;
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
         send_word(op, rand_component(), rand_component(), rand_component(),
                   rand_component(), rand_component(), rand_angle());
      end
   endtask

   task automatic test_drain_pause();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      test_random(20);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = '0;
      req_ax = '0; req_ay = '0; req_bx = '0; req_by = '0;
      req_scalar = '0; req_angle_deg = '0;
      errors = 0;
      done = 0;
      send_idle_pct = 16;
      recv_idle_pct = 87;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(520);
      test_drain_pause();
      send_idle_pct = 87;
      recv_idle_pct = 16;
      test_random(540);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(540);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      done = 1;
      if (errors == 0 && expected_results.size() == 0) begin
         $display("vector2d_alu_top_tb OK");
      end else begin
         $display("vector2d_alu_top_tb NOT OK");
      end
      $finish;
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial rsp_ready = 1'b0;

   always @(posedge clock) begin
      vec_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%t unexpected word rx=%h ry=%h", $time, rsp_rx, rsp_ry);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_rx !== want.rx) begin
               $display("%t rx expected %h actual %h", $time, want.rx, rsp_rx);
               errors++;
            end
            if (rsp_ry !== want.ry) begin
               $display("%t ry expected %h actual %h", $time, want.ry, rsp_ry);
               errors++;
            end
            if (rsp_div_zero !== want.div_zero) begin
               $display("%t div_zero expected %b actual %b", $time, want.div_zero,
                        rsp_div_zero);
               errors++;
            end
            if (rsp_saturated !== want.saturated) begin
               $display("%t saturated expected %b actual %b", $time, want.saturated,
                        rsp_saturated);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (!done && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("vector2d_alu_top_tb NOT OK");
         $finish;
      end
   end

endmodule
